// ===== hdl/ffba_pkg.sv =====
// Shared constants, types and codes of the first-fit block allocator.
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;
    localparam int HEAP_BYTES   = 1048576;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ADDR_W       = 21;
    localparam int SUM_W        = ADDR_W + 2;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NXT_RD,
        S_NXT_CHK,
        S_MARK,
        S_PRV_CHK,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    // One table entry: free mark and payload size.
    typedef struct packed {
        logic              free;
        logic [ADDR_W-1:0] size;
    } t_entry;

endpackage

// ===== hdl/ffba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/first_fit_block_allocator_core.sv =====
// Top level of the first-fit block allocator with coalescing.
// One request is taken at a time: start is accepted while busy is low, and the
// single result appears for one cycle with o_valid, which the receiver must take.
// A request walks the block table in a memory with one read port, reading and
// then checking each entry; a reallocate may walk twice, and a free that merges
// neighbors moves every later entry down one place with a read and a write.
// The heap limit register is written over its own valid/ready channel, which is
// always ready; a request uses the limit that held when it was accepted.
module first_fit_block_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_op,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_req_size,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_req_addr,
    output logic                          o_valid,
    output logic [ffba_pkg::ADDR_W-1:0]   o_result_addr,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_cfg_data
);
    import ffba_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_free_cnt, n_free_cnt;
    logic [ADDR_W-1:0]   r_top, n_top;
    logic [ADDR_W-1:0]   r_heap_limit;
    logic [ADDR_W-1:0]   r_limit, n_limit;
    logic [ADDR_W-1:0]   r_size, n_size;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_find, n_find;
    logic                r_realloc, n_realloc;
    logic                r_phase, n_phase;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [CNT_W-1:0]    r_fidx, n_fidx;
    logic [ADDR_W-1:0]   r_fsize, n_fsize;
    logic [ADDR_W-1:0]   r_res, n_res;
    t_status             r_status, n_status;

    logic                we, re;
    logic [IDX_W-1:0]    waddr, raddr;
    t_entry              wdata, rdata;
    logic [SUM_W-1:0]    need;
    logic [CNT_W-1:0]    fidx_p1, fidx_m1, k_p1;

    ffba_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_result_addr = r_res;
    assign o_status      = r_status;
    assign o_cfg_ready   = 1'b1;

    assign fidx_p1 = r_fidx + CNT_W'(1);
    assign fidx_m1 = r_fidx - CNT_W'(1);
    assign k_p1    = r_idx + CNT_W'(1);
    assign need    = SUM_W'(r_top) + SUM_W'(HEADER_BYTES) + SUM_W'(r_size);

    // Register updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_free_cnt   <= '0;
            r_top        <= '0;
            r_heap_limit <= ADDR_W'(HEAP_BYTES);
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_free_cnt <= n_free_cnt;
            r_top      <= n_top;
            if (i_cfg_valid && o_cfg_ready) begin
                r_heap_limit <= i_cfg_data;
            end
        end
    end

    // Per-request working registers.
    always_ff @(posedge i_clk) begin
        r_limit   <= n_limit;
        r_size    <= n_size;
        r_addr    <= n_addr;
        r_find    <= n_find;
        r_realloc <= n_realloc;
        r_phase   <= n_phase;
        r_idx     <= n_idx;
        r_base    <= n_base;
        r_fidx    <= n_fidx;
        r_fsize   <= n_fsize;
        r_res     <= n_res;
        r_status  <= n_status;
    end

    // Sequencer: table walk, allocate, free with merging, entry removal.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_free_cnt = r_free_cnt;
        n_top      = r_top;
        n_limit    = r_limit;
        n_size     = r_size;
        n_addr     = r_addr;
        n_find     = r_find;
        n_realloc  = r_realloc;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_base     = r_base;
        n_fidx     = r_fidx;
        n_fsize    = r_fsize;
        n_res      = r_res;
        n_status   = r_status;
        we         = 1'b0;
        waddr      = r_idx[IDX_W-1:0];
        wdata      = rdata;
        re         = 1'b0;
        raddr      = r_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_size    = i_req_size;
                    n_addr    = i_req_addr;
                    n_limit   = (r_heap_limit < ADDR_W'(HEAP_BYTES)) ?
                                r_heap_limit : ADDR_W'(HEAP_BYTES);
                    n_idx     = '0;
                    n_base    = '0;
                    n_res     = '0;
                    n_status  = ST_OK;
                    n_realloc = 1'b0;
                    n_find    = 1'b0;
                    n_state   = S_DONE;
                    unique case (t_op'(i_op))
                        OP_ALLOC: begin
                            if (i_req_size != '0) n_state = S_SCAN_RD;
                        end
                        OP_FREE: begin
                            if (i_req_addr != '0) begin
                                n_find  = 1'b1;
                                n_state = S_SCAN_RD;
                            end
                        end
                        OP_REALLOC: begin
                            if (i_req_addr == '0) begin
                                if (i_req_size != '0) n_state = S_SCAN_RD;
                            end else begin
                                n_find    = 1'b1;
                                n_realloc = (i_req_size != '0);
                                n_state   = S_SCAN_RD;
                            end
                        end
                        OP_NONE: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Issue a read of the next entry; at the table end, report not found or no space, or append.
            S_SCAN_RD: begin
                if (r_idx < r_count) begin
                    re      = 1'b1;
                    n_state = S_SCAN_CHK;
                end else if (r_find) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else if (r_count >= CNT_W'(MAX_BLOCKS) || need > SUM_W'(r_limit)) begin
                    n_res    = '0;
                    n_status = ST_NOSPACE;
                    n_state  = S_DONE;
                end else begin
                    // Append a new block at the heap top.
                    we         = 1'b1;
                    waddr      = r_count[IDX_W-1:0];
                    wdata.free = 1'b0;
                    wdata.size = r_size;
                    n_count    = r_count + CNT_W'(1);
                    n_res      = r_top + ADDR_W'(HEADER_BYTES);
                    n_top      = ADDR_W'(need);
                    n_state    = r_realloc ? S_NXT_RD : S_DONE;
                end
            end

            S_SCAN_CHK: begin
                n_idx   = r_idx + CNT_W'(1);
                n_base  = r_base + ADDR_W'(HEADER_BYTES) + rdata.size;
                n_state = S_SCAN_RD;
                if (r_find) begin
                    if (r_base + ADDR_W'(HEADER_BYTES) == r_addr) begin
                        if (rdata.free) begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_DONE;
                        end else begin
                            n_fidx  = r_idx;
                            n_fsize = rdata.size;
                            n_find  = 1'b0;
                            if (!r_realloc) begin
                                n_state = S_NXT_RD;
                            end else if (rdata.size == r_size) begin
                                n_res   = r_addr;
                                n_state = S_DONE;
                            end else begin
                                // Restart the walk as an allocation.
                                n_idx  = '0;
                                n_base = '0;
                            end
                        end
                    end
                end else if (rdata.free && rdata.size >= r_size) begin
                    we         = 1'b1;
                    wdata.free = 1'b0;
                    wdata.size = rdata.size;
                    if (r_free_cnt != '0) n_free_cnt = r_free_cnt - CNT_W'(1);
                    n_res   = r_base + ADDR_W'(HEADER_BYTES);
                    n_state = r_realloc ? S_NXT_RD : S_DONE;
                end
            end

            // Look at the next neighbor of the block being freed.
            S_NXT_RD: begin
                raddr = fidx_p1[IDX_W-1:0];
                if (fidx_p1 < r_count) begin
                    re      = 1'b1;
                    n_state = S_NXT_CHK;
                end else begin
                    n_state = S_MARK;
                end
            end

            S_NXT_CHK: begin
                if (rdata.free) begin
                    n_fsize = r_fsize + rdata.size + ADDR_W'(HEADER_BYTES);
                    if (r_free_cnt != '0) n_free_cnt = r_free_cnt - CNT_W'(1);
                    n_idx   = fidx_p1;
                    n_phase = 1'b0;
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_MARK;
                end
            end

            // Mark the block free and read its previous neighbor.
            S_MARK: begin
                we         = 1'b1;
                waddr      = r_fidx[IDX_W-1:0];
                wdata.free = 1'b1;
                wdata.size = r_fsize;
                n_free_cnt = r_free_cnt + CNT_W'(1);
                raddr      = fidx_m1[IDX_W-1:0];
                if (r_fidx != '0) begin
                    re      = 1'b1;
                    n_state = S_PRV_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_PRV_CHK: begin
                if (rdata.free) begin
                    we         = 1'b1;
                    waddr      = fidx_m1[IDX_W-1:0];
                    wdata.free = 1'b1;
                    wdata.size = rdata.size + r_fsize + ADDR_W'(HEADER_BYTES);
                    n_free_cnt = r_free_cnt - CNT_W'(1);
                    n_idx      = r_fidx;
                    n_phase    = 1'b1;
                    n_state    = S_SH_RD;
                end else begin
                    n_state = S_DONE;
                end
            end

            // Remove entry r_idx by moving later entries down one place.
            S_SH_RD: begin
                raddr = k_p1[IDX_W-1:0];
                if (k_p1 < r_count) begin
                    re      = 1'b1;
                    n_state = S_SH_WR;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = r_phase ? S_DONE : S_MARK;
                end
            end

            S_SH_WR: begin
                we      = 1'b1;
                wdata   = rdata;
                n_idx   = k_p1;
                n_state = S_SH_RD;
            end

            S_DONE: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result strobe lasts a single cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // The table never holds more blocks than it has rows.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table depth");

    // The heap top never passes the fixed heap size.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= ADDR_W'(HEAP_BYTES))
        else $error("heap top beyond heap size");

    // An accepted request makes the block busy in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) (start && !busy) |=> busy)
        else $error("request accepted without going busy");

endmodule

// ===== tb/first_fit_block_allocator_core_tb.sv =====
// Self-checking testbench for the first-fit block allocator core.
`timescale 1ns / 100ps

module first_fit_block_allocator_core_tb;
    import ffba_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 6 * MAX_BLOCKS + 20;
    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_op = OP_ALLOC;
    logic [ADDR_W-1:0] i_req_size = '0;
    logic [ADDR_W-1:0] i_req_addr = '0;
    logic              o_valid;
    logic [ADDR_W-1:0] o_result_addr;
    logic [1:0]        o_status;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [ADDR_W-1:0] i_cfg_data = '0;

    first_fit_block_allocator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_req_size(i_req_size), .i_req_addr(i_req_addr),
        .o_valid(o_valid), .o_result_addr(o_result_addr), .o_status(o_status),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    typedef struct {
        logic [ADDR_W-1:0] addr;
        t_status           st;
    } t_grant;

    // A row with typed set carries its own expected result.
    typedef struct {
        t_op               op;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] exp_addr;
        t_status           exp_st;
        bit                typed;
    } t_row;

    t_grant pending_grants[$];
    int     err_cnt = 0;
    bit     idle_on = 1'b1;

    // Shadow copy of the allocator's block table and heap registers.
    logic [ADDR_W-1:0] tbl_size[MAX_BLOCKS];
    bit                tbl_free[MAX_BLOCKS];
    int                tbl_cnt = 0;
    longint            heap_top = 0;
    longint            heap_limit = HEAP_BYTES;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Index of the in-use block whose payload starts at addr, or -1.
    function automatic int find_live(input longint addr);
        longint base;
        base = 0;
        for (int i = 0; i < tbl_cnt; i++) begin
            if (base + HEADER_BYTES == addr) return tbl_free[i] ? -1 : i;
            base += HEADER_BYTES + tbl_size[i];
        end
        return -1;
    endfunction

    function automatic longint payload_of(input int idx);
        longint base;
        base = HEADER_BYTES;
        for (int i = 0; i < idx; i++) base += HEADER_BYTES + tbl_size[i];
        return base;
    endfunction

    function automatic void drop_entry(input int idx);
        for (int i = idx; i < tbl_cnt - 1; i++) begin
            tbl_size[i] = tbl_size[i+1];
            tbl_free[i] = tbl_free[i+1];
        end
        tbl_cnt--;
    endfunction

    // First fit without splitting, else append at the heap top.
    function automatic t_status first_fit(input longint sz, output longint addr);
        longint base;
        longint lim;
        base = 0;
        lim = heap_limit < HEAP_BYTES ? heap_limit : HEAP_BYTES;
        addr = 0;
        if (sz == 0) return ST_OK;
        for (int i = 0; i < tbl_cnt; i++) begin
            if (tbl_free[i] && tbl_size[i] >= sz) begin
                tbl_free[i] = 1'b0;
                addr = base + HEADER_BYTES;
                return ST_OK;
            end
            base += HEADER_BYTES + tbl_size[i];
        end
        if (tbl_cnt >= MAX_BLOCKS || heap_top + HEADER_BYTES + sz > lim) return ST_NOSPACE;
        tbl_size[tbl_cnt] = sz[ADDR_W-1:0];
        tbl_free[tbl_cnt] = 1'b0;
        tbl_cnt++;
        addr = heap_top + HEADER_BYTES;
        heap_top += HEADER_BYTES + sz;
        return ST_OK;
    endfunction

    // Release a block and coalesce with the next, then the previous neighbor.
    function automatic void release_block(input int idx);
        if (idx + 1 < tbl_cnt && tbl_free[idx+1]) begin
            tbl_size[idx] += tbl_size[idx+1] + HEADER_BYTES;
            drop_entry(idx + 1);
        end
        tbl_free[idx] = 1'b1;
        if (idx > 0 && tbl_free[idx-1]) begin
            tbl_size[idx-1] += tbl_size[idx] + HEADER_BYTES;
            drop_entry(idx);
        end
    endfunction

    function automatic t_status release_addr(input longint addr);
        int idx;
        if (addr == 0) return ST_OK;
        idx = find_live(addr);
        if (idx < 0) return ST_NOTFOUND;
        release_block(idx);
        return ST_OK;
    endfunction

    function automatic t_grant grant_for(input t_op op, input logic [ADDR_W-1:0] sz,
                                         input logic [ADDR_W-1:0] ad);
        t_grant g;
        longint ra;
        int     idx;
        ra = 0;
        g.st = ST_OK;
        case (op)
            OP_ALLOC: g.st = first_fit(sz, ra);
            OP_FREE:  g.st = release_addr(ad);
            OP_REALLOC: begin
                if (ad == 0) g.st = first_fit(sz, ra);
                else if (sz == 0) g.st = release_addr(ad);
                else begin
                    idx = find_live(ad);
                    if (idx < 0) g.st = ST_NOTFOUND;
                    else if (tbl_size[idx] == sz) ra = ad;
                    else begin
                        g.st = first_fit(sz, ra);
                        if (g.st == ST_OK) release_block(idx);
                        else ra = 0;
                    end
                end
            end
            default: ;
        endcase
        g.addr = ra[ADDR_W-1:0];
        return g;
    endfunction

    // Offer one request; on the transfer, push the expected grant.
    task automatic send_req(input t_op op, input logic [ADDR_W-1:0] sz,
                            input logic [ADDR_W-1:0] ad, input bit typed,
                            input t_grant typed_grant);
        t_grant g;
        if (idle_on && $urandom_range(99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= op;
        i_req_size <= sz;
        i_req_addr <= ad;
        do @(posedge i_clk); while (busy);
        g = grant_for(op, sz, ad);
        if (typed) begin
            if (g.addr !== typed_grant.addr || g.st !== typed_grant.st)
                report_mismatch($sformatf("table row op %0d disagrees with predictor", op));
            g = typed_grant;
        end
        pending_grants.push_back(g);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [ADDR_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        heap_limit = v;
    endtask

    // Random size, mostly small so the table fills and gets reused.
    function automatic logic [ADDR_W-1:0] rand_size();
        int r;
        r = $urandom_range(99);
        if (r < 3) return '0;
        if (r < 6) return ALL_ONES;
        if (r < 9) return ADDR_W'($urandom());
        if (r < 70) return ADDR_W'($urandom_range(1, 64));
        return ADDR_W'($urandom_range(1, 4096));
    endfunction

    // Build one well-formed request against a live block, or noise.
    task automatic send_random();
        int                r;
        int                live_n;
        int                pick;
        int                idx;
        logic [ADDR_W-1:0] ad;
        logic [ADDR_W-1:0] sz;
        t_grant            none;
        none = '{'0, ST_OK};
        live_n = 0;
        idx = -1;
        for (int i = 0; i < tbl_cnt; i++) if (!tbl_free[i]) live_n++;
        if (live_n > 0) begin
            pick = $urandom_range(live_n - 1);
            for (int i = 0; i < tbl_cnt && idx < 0; i++)
                if (!tbl_free[i]) begin
                    if (pick == 0) idx = i;
                    pick--;
                end
        end
        ad = idx >= 0 ? ADDR_W'(payload_of(idx)) : '0;
        sz = rand_size();
        r = $urandom_range(99);
        if (r < 45) send_req(OP_ALLOC, sz, ADDR_W'($urandom()), 1'b0, none);
        else if (r < 72) send_req(OP_FREE, ADDR_W'($urandom()), ad, 1'b0, none);
        else if (r < 88) begin
            if (idx >= 0 && $urandom_range(3) == 0) sz = tbl_size[idx];
            send_req(OP_REALLOC, sz, ad, 1'b0, none);
        end else if (r < 96) begin
            send_req(t_op'($urandom_range(1, 2)), sz, ADDR_W'($urandom()), 1'b0, none);
        end else begin
            send_req(OP_NONE, ADDR_W'($urandom()), ADDR_W'($urandom()), 1'b0, none);
        end
    endtask

    // Result checker: every strobe must match the oldest pending grant.
    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && o_valid) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("result with nothing pending");
            end else begin
                g = pending_grants.pop_front();
                if (o_result_addr !== g.addr)
                    report_mismatch($sformatf("result_addr %0d, want %0d",
                                              o_result_addr, g.addr));
                if (o_status !== g.st)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, g.st));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    int stall_cnt = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("first_fit_block_allocator_core verification failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    t_row dir_rows[21];
    logic [ADDR_W-1:0] limits[6];

    initial begin
        dir_rows[0]  = '{OP_ALLOC,   0,        0,        0,   ST_OK,       1'b1};
        dir_rows[1]  = '{OP_FREE,    0,        0,        0,   ST_OK,       1'b1};
        dir_rows[2]  = '{OP_FREE,    0,        12345,    0,   ST_NOTFOUND, 1'b1};
        dir_rows[3]  = '{OP_ALLOC,   100,      0,        32,  ST_OK,       1'b1};
        dir_rows[4]  = '{OP_ALLOC,   1048576,  0,        0,   ST_NOSPACE,  1'b1};
        dir_rows[5]  = '{OP_REALLOC, 50,       0,        0,   ST_OK,       1'b0};
        dir_rows[6]  = '{OP_REALLOC, 100,      32,       32,  ST_OK,       1'b1};
        dir_rows[7]  = '{OP_REALLOC, 0,        32,       0,   ST_OK,       1'b1};
        dir_rows[8]  = '{OP_FREE,    0,        32,       0,   ST_NOTFOUND, 1'b1};
        dir_rows[9]  = '{OP_ALLOC,   80,       0,        32,  ST_OK,       1'b1};
        dir_rows[10] = '{OP_REALLOC, 200,      164,      0,   ST_OK,       1'b0};
        dir_rows[11] = '{OP_NONE,    7,        32,       0,   ST_OK,       1'b1};
        dir_rows[12] = '{OP_REALLOC, 5,        999,      0,   ST_NOTFOUND, 1'b1};
        dir_rows[13] = '{OP_REALLOC, 1048576,  32,       0,   ST_NOSPACE,  1'b1};
        dir_rows[14] = '{OP_FREE,    0,        246,      0,   ST_OK,       1'b0};
        dir_rows[15] = '{OP_FREE,    0,        32,       0,   ST_OK,       1'b0};
        dir_rows[16] = '{OP_ALLOC,   1,        0,        0,   ST_OK,       1'b0};
        dir_rows[17] = '{OP_ALLOC,   ALL_ONES, 0,        0,   ST_NOSPACE,  1'b1};
        dir_rows[18] = '{OP_FREE,    0,        ALL_ONES, 0,   ST_NOTFOUND, 1'b1};
        dir_rows[19] = '{OP_REALLOC, 0,        0,        0,   ST_OK,       1'b1};
        dir_rows[20] = '{OP_NONE,    ALL_ONES, ALL_ONES, 0,   ST_OK,       1'b1};
        limits = '{ALL_ONES, 4096, 0, 1048576, 300000, 0};
        limits[5] = ADDR_W'($urandom_range(0, 1048576));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at the reset heap limit.
        foreach (dir_rows[k])
            send_req(dir_rows[k].op, dir_rows[k].size, dir_rows[k].addr, dir_rows[k].typed,
                     '{dir_rows[k].exp_addr, dir_rows[k].exp_st});

        // Random phases, each under its own heap limit.
        foreach (limits[p]) begin
            wait_drained();
            write_limit(limits[p]);
            idle_on = (p != 3);
            for (int n = 0; n < 265; n++) begin
                if (n == 120) wait_drained();
                send_random();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("first_fit_block_allocator_core verification clean");
        end else begin
            $display("first_fit_block_allocator_core verification failed");
        end
        $finish;
    end

endmodule
